[sv/dbct_pkg.sv]
// dbct_pkg: shared types and constants for the disk buffer cache tag manager
// depends on nothing; used by the interfaces and by every module but dbct_tag_ram
`default_nettype none

package dbct_pkg;

  // default sizes
  localparam int ENTRIES_DEF   = 16;
  localparam int LOCK_BITS_DEF = 8;

  // fixed payload widths
  localparam int KIND_W   = 2;
  localparam int BLOCK_W  = 32;
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;

  // disk size register after reset: every block number but the all-ones one in range
  localparam logic [BLOCK_W-1:0] DISK_BLOCKS_RST = '1;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_LOCK   = 2'd0,
    KIND_UNLOCK = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // disk command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_BUF       = 3'd1,
    ST_RANGE        = 3'd2,
    ST_NOT_LOCKED   = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_FLUSH_LOCKED = 3'd5,
    ST_LOCK_FULL    = 3'd6
  } status_t;

  // one result item
  typedef struct packed {
    cmd_t               command;
    logic [BLOCK_W-1:0] command_block;
    logic [SLOT_W-1:0]  slot;
    status_t            status;
    logic               last;
  } rsp_t;

  // flags from the shared compare unit for the entry under test
  typedef struct packed {
    logic hit;       // valid and same block
    logic free;      // not valid
    logic unlocked;  // valid with lock count zero
    logic locked;    // valid with lock count non-zero
  } match_t;

endpackage

`default_nettype wire

[sv/dbct_if.sv]
// dbct_req_if and dbct_rsp_if: valid/ready channels for request and result items
// depends on dbct_pkg for payload widths
`default_nettype none

interface dbct_req_if
  import dbct_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BLOCK_W-1:0] block;
  logic               write_flag;

  modport source (output valid, kind, block, write_flag, input ready);
  modport sink   (input valid, kind, block, write_flag, output ready);
endinterface

interface dbct_rsp_if
  import dbct_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [BLOCK_W-1:0]  command_block;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, command, command_block, slot, status, last, input ready);
  modport sink   (input valid, command, command_block, slot, status, last, output ready);
endinterface

`default_nettype wire

[sv/dbct_tag_ram.sv]
// dbct_tag_ram: entry store holding lock count and block number per entry
// one write port, one read port with registered read data; no dependencies
`default_nettype none

module dbct_tag_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/dbct_match.sv]
// dbct_match: shared compare unit, tests one entry against the request block
// depends on dbct_pkg for match_t
`default_nettype none

module dbct_match
  import dbct_pkg::*;
#(
  parameter int LOCK_BITS = LOCK_BITS_DEF
) (
  input  wire logic                 entry_valid,
  input  wire logic [LOCK_BITS-1:0] entry_lock,
  input  wire logic [BLOCK_W-1:0]   entry_block,
  input  wire logic [BLOCK_W-1:0]   key,
  output      match_t               m
);

  logic lock_zero;

  // tag compare and lock state of the entry
  always_comb begin
    lock_zero  = (entry_lock == '0);
    m.hit      = entry_valid && (entry_block == key);
    m.free     = !entry_valid;
    m.unlocked = entry_valid && lock_zero;
    m.locked   = entry_valid && !lock_zero;
  end

endmodule

`default_nettype wire

[sv/dbct_ctrl.sv]
// dbct_ctrl: sequencer that scans the entry store and issues result items
// depends on dbct_pkg, dbct_if; drives dbct_tag_ram and reads dbct_match
`default_nettype none

module dbct_ctrl
  import dbct_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int LOCK_BITS = LOCK_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [BLOCK_W-1:0]             disk_blocks,
  dbct_req_if.sink                            req,
  dbct_rsp_if.source                          rsp,
  output      logic                           mem_re,
  output      logic [$clog2(ENTRIES)-1:0]     mem_raddr,
  output      logic                           mem_we,
  output      logic [$clog2(ENTRIES)-1:0]     mem_waddr,
  output      logic [LOCK_BITS+BLOCK_W-1:0]   mem_wdata,
  input  wire logic [LOCK_BITS+BLOCK_W-1:0]   mem_rdata,
  output      logic                           chk_valid,
  output      logic [BLOCK_W-1:0]             key,
  input  wire match_t                         m
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_GRANT
  } state_t;

  state_t state;

  // request held for the whole operation
  kind_t              op_kind;
  logic [BLOCK_W-1:0] op_block;
  logic               op_write;

  // scan pipeline: read issue, then check
  logic             issue;
  logic [IDX_W-1:0] scan_idx;
  logic             p_vld;
  logic [IDX_W-1:0] p_idx;

  // scan findings
  logic                 hit_f;
  logic [IDX_W-1:0]     hit_idx;
  logic [LOCK_BITS-1:0] hit_lock;
  logic                 free_f;
  logic [IDX_W-1:0]     free_idx;
  logic                 sel_f;       // victim for lock, first locked for flush
  logic [IDX_W-1:0]     sel_idx;
  logic [BLOCK_W-1:0]   sel_block;
  logic [IDX_W-1:0]     grant_idx;

  // per-entry flags
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dirty_q;

  // output register
  logic out_vld;
  rsp_t out_q;

  logic                 out_free;
  logic                 chk;
  logic                 wb_now;
  logic                 adv;
  logic [LOCK_BITS-1:0] r_lock;
  logic [BLOCK_W-1:0]   r_block;
  logic                 fin_go;
  logic                 grant_go;

  assign r_lock  = mem_rdata[LOCK_BITS+BLOCK_W-1:BLOCK_W];
  assign r_block = mem_rdata[BLOCK_W-1:0];

  // handshake and payload
  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_vld;
  assign rsp.command       = out_q.command;
  assign rsp.command_block = out_q.command_block;
  assign rsp.slot          = out_q.slot;
  assign rsp.status        = out_q.status;
  assign rsp.last          = out_q.last;

  // feed to the compare unit
  assign chk_valid = valid_q[p_idx];
  assign key       = op_block;

  // scan control: flush write-backs hold the scan while the output is full
  always_comb begin
    out_free = !out_vld || rsp.ready;
    chk      = (state == S_SCAN) && p_vld;
    wb_now   = chk && (op_kind == KIND_FLUSH) && m.unlocked && dirty_q[p_idx];
    adv      = (state == S_SCAN) && !(wb_now && !out_free);
    fin_go   = (state == S_FINISH) && out_free;
    grant_go = (state == S_GRANT) && out_free;
  end

  // store read and write
  always_comb begin
    mem_re    = adv && issue;
    mem_raddr = scan_idx;
    mem_we    = 1'b0;
    mem_waddr = hit_idx;
    mem_wdata = {hit_lock + LOCK_BITS'(1), op_block};
    if (fin_go && hit_f) begin
      if (op_kind == KIND_LOCK && hit_lock != '1) begin
        mem_we = 1'b1;
      end else if (op_kind == KIND_UNLOCK && hit_lock != '0) begin
        mem_we    = 1'b1;
        mem_wdata = {hit_lock - LOCK_BITS'(1), op_block};
      end
    end
    if (grant_go) begin
      mem_we    = 1'b1;
      mem_waddr = grant_idx;
      mem_wdata = {LOCK_BITS'(1), op_block};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
      valid_q <= '0;
      dirty_q <= '0;
      issue   <= 1'b0;
      p_vld   <= 1'b0;
    end else begin
      if (out_vld && rsp.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_kind  <= kind_t'(req.kind);
            op_block <= req.block;
            op_write <= req.write_flag;
            hit_f    <= 1'b0;
            free_f   <= 1'b0;
            sel_f    <= 1'b0;
            scan_idx <= '0;
            issue    <= 1'b1;
            p_vld    <= 1'b0;
            if (req.kind == KIND_LOCK || req.kind == KIND_UNLOCK ||
                req.kind == KIND_FLUSH) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end

        S_SCAN: begin
          if (adv) begin
            // advance the read pipeline
            p_vld <= issue;
            p_idx <= scan_idx;
            if (issue) begin
              if (scan_idx == LAST_IDX) begin
                issue <= 1'b0;
              end else begin
                scan_idx <= scan_idx + 1'b1;
              end
            end
            // record findings for the entry under test
            if (chk) begin
              if (m.hit && !hit_f) begin
                hit_f    <= 1'b1;
                hit_idx  <= p_idx;
                hit_lock <= r_lock;
              end
              if (m.free && !free_f) begin
                free_f   <= 1'b1;
                free_idx <= p_idx;
              end
              if (!sel_f && ((op_kind == KIND_FLUSH && m.locked) ||
                             (op_kind != KIND_FLUSH && m.unlocked))) begin
                sel_f     <= 1'b1;
                sel_idx   <= p_idx;
                sel_block <= r_block;
              end
              if (wb_now) begin
                out_vld          <= 1'b1;
                out_q            <= '{CMD_WRITE, r_block, SLOT_W'(p_idx), ST_OK, 1'b0};
                valid_q[p_idx]   <= 1'b0;
                dirty_q[p_idx]   <= 1'b0;
              end
              if (p_idx == LAST_IDX) begin
                state <= S_FINISH;
              end
            end
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_vld <= 1'b1;
            state   <= S_IDLE;
            case (op_kind)
              KIND_LOCK: begin
                if (hit_f) begin
                  out_q <= '{CMD_NONE, op_block, SLOT_W'(hit_idx),
                             (hit_lock == '1) ? ST_LOCK_FULL : ST_OK, 1'b1};
                end else if (op_block >= disk_blocks) begin
                  out_q <= '{CMD_NONE, op_block, '0, ST_RANGE, 1'b1};
                end else if (free_f) begin
                  out_vld   <= 1'b0;
                  grant_idx <= free_idx;
                  state     <= S_GRANT;
                end else if (sel_f) begin
                  // evict the victim, writing it back first if dirty
                  grant_idx <= sel_idx;
                  state     <= S_GRANT;
                  if (dirty_q[sel_idx]) begin
                    out_q            <= '{CMD_WRITE, sel_block, SLOT_W'(sel_idx), ST_OK, 1'b0};
                    dirty_q[sel_idx] <= 1'b0;
                  end else begin
                    out_vld <= 1'b0;
                  end
                end else begin
                  out_q <= '{CMD_NONE, op_block, '0, ST_NO_BUF, 1'b1};
                end
              end
              KIND_UNLOCK: begin
                if (!hit_f) begin
                  out_q <= '{CMD_NONE, op_block, '0, ST_NOT_FOUND, 1'b1};
                end else if (hit_lock == '0) begin
                  out_q <= '{CMD_NONE, op_block, SLOT_W'(hit_idx), ST_NOT_LOCKED, 1'b1};
                end else begin
                  if (op_write) begin
                    dirty_q[hit_idx] <= 1'b1;
                  end
                  out_q <= '{CMD_NONE, op_block, SLOT_W'(hit_idx), ST_OK, 1'b1};
                end
              end
              KIND_FLUSH: begin
                if (sel_f) begin
                  out_q <= '{CMD_NONE, sel_block, SLOT_W'(sel_idx), ST_FLUSH_LOCKED, 1'b1};
                end else begin
                  out_q <= '{CMD_NONE, '0, '0, ST_OK, 1'b1};
                end
              end
              default: begin
                out_q <= '{CMD_NONE, '0, '0, ST_OK, 1'b1};
              end
            endcase
          end
        end

        S_GRANT: begin
          // new entry: valid, clean, locked once
          if (out_free) begin
            out_vld            <= 1'b1;
            out_q              <= '{CMD_READ, op_block, SLOT_W'(grant_idx), ST_OK, 1'b1};
            valid_q[grant_idx] <= 1'b1;
            dirty_q[grant_idx] <= 1'b0;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/disk_buffer_cache_tags.sv]
// disk_buffer_cache_tags: top level of the disk buffer cache tag manager
// depends on dbct_pkg, dbct_if, dbct_tag_ram, dbct_match, dbct_ctrl
//
//  channel  dir  handshake          payload
//  req      in   valid / ready      kind, block, write_flag
//  rsp      out  valid / ready      command, command_block, slot, status, last
//  cfg      in   cfg_we             cfg_wdata (disk_blocks)
//
// one item at a time; lock, unlock and flush scan every entry, reading one entry a
// cycle from the entry store through the shared compare unit unless a flush
// write-back stalls; a lock granted an entry adds a grant state for the read
// an unused operation code skips the scan and goes straight to the final item
// reset clears the valid and dirty flags at once; no clearing pass
// a result item not yet taken stalls flush write-backs, the final item and the grant
`default_nettype none

module disk_buffer_cache_tags
  import dbct_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int LOCK_BITS = LOCK_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [BLOCK_W-1:0] cfg_wdata,
  dbct_req_if.sink                req,
  dbct_rsp_if.source              rsp
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int WORD_W = LOCK_BITS + BLOCK_W;

  logic [BLOCK_W-1:0] disk_blocks;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mem_rdata;
  logic               chk_valid;
  logic [BLOCK_W-1:0] key;
  match_t             m;

  // disk size register
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= DISK_BLOCKS_RST;
    end else if (cfg_we) begin
      disk_blocks <= cfg_wdata;
    end
  end

  // entry store
  dbct_tag_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared compare unit
  dbct_match #(
    .LOCK_BITS (LOCK_BITS)
  ) u_match (
    .entry_valid (chk_valid),
    .entry_lock  (mem_rdata[WORD_W-1:BLOCK_W]),
    .entry_block (mem_rdata[BLOCK_W-1:0]),
    .key         (key),
    .m           (m)
  );

  // sequencer
  dbct_ctrl #(
    .ENTRIES   (ENTRIES),
    .LOCK_BITS (LOCK_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .disk_blocks (disk_blocks),
    .req         (req),
    .rsp         (rsp),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .chk_valid   (chk_valid),
    .key         (key),
    .m           (m)
  );

endmodule

`default_nettype wire

[verif/dbct_tag_checker.sv]
`timescale 1ns / 100ps
// dbct_tag_checker: keeps its own copy of the buffer table, works out the result items
// of every accepted request and compares them with the result channel
// depends on dbct_pkg and the dbct_req_if / dbct_rsp_if channels
`default_nettype none

module dbct_tag_checker
  import dbct_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int LOCK_BITS = LOCK_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [BLOCK_W-1:0] cfg_wdata,
  dbct_req_if                     req,
  dbct_rsp_if                     rsp,
  output int                      errors,
  output int                      outstanding
);

  localparam logic [LOCK_BITS-1:0] LOCKS_FULL = '1;
  localparam int REPORT_MAX = 10;

  // predicted table contents and disk size
  logic [BLOCK_W-1:0]   tag_blk   [ENTRIES];
  logic                 tag_vld   [ENTRIES];
  logic [LOCK_BITS-1:0] tag_locks [ENTRIES];
  logic                 tag_dirty [ENTRIES];
  logic [BLOCK_W-1:0]   disk_limit;

  // result items still to arrive, oldest first
  rsp_t due_q [$];
  int   n_fail = 0;

  task automatic add_due(input cmd_t c, input logic [BLOCK_W-1:0] b, input int s,
                         input status_t st, input logic l);
    rsp_t r;
    r.command       = c;
    r.command_block = b;
    r.slot          = SLOT_W'(s);
    r.status        = st;
    r.last          = l;
    due_q.push_back(r);
  endtask

  // lowest valid entry that holds the block, or -1
  function automatic int find_tag(input logic [BLOCK_W-1:0] b);
    int hit;
    hit = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (tag_vld[i] && tag_blk[i] == b) hit = i;
    return hit;
  endfunction

  // update the table for one request and queue its result items
  task automatic apply_request(input logic [KIND_W-1:0] k, input logic [BLOCK_W-1:0] b,
                               input logic wr);
    int hit;
    int pick;
    int held;
    case (k)
      KIND_LOCK: begin
        hit = find_tag(b);
        if (hit >= 0) begin
          // hit: no range check, count saturates with a status
          if (tag_locks[hit] == LOCKS_FULL) begin
            add_due(CMD_NONE, b, hit, ST_LOCK_FULL, 1'b1);
          end else begin
            tag_locks[hit]++;
            add_due(CMD_NONE, b, hit, ST_OK, 1'b1);
          end
        end else if (b >= disk_limit) begin
          add_due(CMD_NONE, b, 0, ST_RANGE, 1'b1);
        end else begin
          pick = -1;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!tag_vld[i]) pick = i;
          // no free entry: evict the lowest unlocked one
          if (pick < 0) begin
            for (int i = ENTRIES - 1; i >= 0; i--)
              if (tag_vld[i] && tag_locks[i] == 0) pick = i;
            if (pick >= 0 && tag_dirty[pick])
              add_due(CMD_WRITE, tag_blk[pick], pick, ST_OK, 1'b0);
          end
          if (pick < 0) begin
            add_due(CMD_NONE, b, 0, ST_NO_BUF, 1'b1);
          end else begin
            tag_vld[pick]   = 1'b1;
            tag_blk[pick]   = b;
            tag_locks[pick] = LOCK_BITS'(1);
            tag_dirty[pick] = 1'b0;
            add_due(CMD_READ, b, pick, ST_OK, 1'b1);
          end
        end
      end
      KIND_UNLOCK: begin
        hit = find_tag(b);
        if (hit < 0) begin
          add_due(CMD_NONE, b, 0, ST_NOT_FOUND, 1'b1);
        end else if (tag_locks[hit] == 0) begin
          add_due(CMD_NONE, b, hit, ST_NOT_LOCKED, 1'b1);
        end else begin
          if (wr) tag_dirty[hit] = 1'b1;
          tag_locks[hit]--;
          add_due(CMD_NONE, b, hit, ST_OK, 1'b1);
        end
      end
      KIND_FLUSH: begin
        // write back and free dirty unlocked entries, remember the first locked one
        held = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tag_vld[i]) begin
            if (tag_locks[i] != 0) begin
              if (held < 0) held = i;
            end else if (tag_dirty[i]) begin
              add_due(CMD_WRITE, tag_blk[i], i, ST_OK, 1'b0);
              tag_dirty[i] = 1'b0;
              tag_vld[i]   = 1'b0;
            end
          end
        end
        if (held >= 0) add_due(CMD_NONE, tag_blk[held], held, ST_FLUSH_LOCKED, 1'b1);
        else add_due(CMD_NONE, '0, 0, ST_OK, 1'b1);
      end
      default: begin
        add_due(CMD_NONE, '0, 0, ST_OK, 1'b1);
      end
    endcase
  endtask

  // results first, then config, then new requests: a new request cannot own a result yet
  always @(posedge clk) begin
    rsp_t  want;
    string exp_s;
    string got_s;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_blk[i]   = '0;
        tag_vld[i]   = 1'b0;
        tag_locks[i] = '0;
        tag_dirty[i] = 1'b0;
      end
      disk_limit = DISK_BLOCKS_RST;
      due_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_q.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_MAX)
            $display("%0t: unexpected result item cmd=%0d blk=%h slot=%0d st=%0d last=%0d",
                     $realtime, rsp.command, rsp.command_block, rsp.slot, rsp.status,
                     rsp.last);
        end else begin
          want = due_q.pop_front();
          if (rsp.command !== want.command || rsp.command_block !== want.command_block ||
              rsp.slot !== want.slot || rsp.status !== want.status ||
              rsp.last !== want.last) begin
            n_fail++;
            if (n_fail <= REPORT_MAX) begin
              exp_s = $sformatf("cmd=%0d blk=%h slot=%0d st=%0d last=%0d", want.command,
                                want.command_block, want.slot, want.status, want.last);
              got_s = $sformatf("cmd=%0d blk=%h slot=%0d st=%0d last=%0d", rsp.command,
                                rsp.command_block, rsp.slot, rsp.status, rsp.last);
              $display("%0t: result mismatch: expected %s, got %s", $realtime, exp_s,
                       got_s);
            end
          end
        end
      end
      if (cfg_we) disk_limit = cfg_wdata;
      if (req.valid && req.ready) apply_request(req.kind, req.block, req.write_flag);
    end
    errors      <= n_fail;
    outstanding <= due_q.size();
  end

endmodule

`default_nettype wire

[verif/tb_disk_buffer_cache_tags.sv]
`timescale 1ns / 100ps
// tb_disk_buffer_cache_tags: drives lock, unlock and flush requests and disk size writes
// into the tag manager, with a stalling receiver; depends on dbct_pkg, dbct_if,
// the block itself and dbct_tag_checker, which does all prediction and comparison
`default_nettype none

module tb_disk_buffer_cache_tags;
  import dbct_pkg::*;

  localparam int ENTRIES   = ENTRIES_DEF;
  localparam int LOCK_BITS = LOCK_BITS_DEF;

  // operation code the block does not use
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int POOL          = 24;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 26;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 4 * ENTRIES;
  localparam logic [BLOCK_W-1:0] HOT_BLOCK  = 32'hC0DE_0000;
  localparam logic [BLOCK_W-1:0] FILL_BASE  = 32'h7000_0000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [BLOCK_W-1:0] cfg_wdata;
  int                 errors;
  int                 outstanding;

  dbct_req_if req ();
  dbct_rsp_if rsp ();

  // sender burst state and blocks believed locked
  int                 burst_left;
  int                 gap_max;
  logic [BLOCK_W-1:0] held_q [$];
  bit                 rx_hold = 1'b0;

  disk_buffer_cache_tags #(
    .ENTRIES   (ENTRIES),
    .LOCK_BITS (LOCK_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  dbct_tag_checker #(
    .ENTRIES   (ENTRIES),
    .LOCK_BITS (LOCK_BITS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req         (req),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: rotating stall pattern, plus one long hold-off on request
  initial begin
    int rx_cyc;
    rx_cyc    = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      rx_cyc++;
      case ((rx_cyc / 96) % 4)
        0: rsp.ready = 1'b1;
        1: rsp.ready = (rx_cyc % 5) != 2;
        2: rsp.ready = 1'($urandom_range(0, 1));
        default: rsp.ready = (rx_cyc % 16) < 5;
      endcase
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // offer one request item, then keep valid for the burst or idle a while
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [BLOCK_W-1:0] b,
                           input logic w);
    int gap;
    req.valid      = 1'b1;
    req.kind       = k;
    req.block      = b;
    req.write_flag = w;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req.valid = 1'b0;
      if (gap_max == 0) gap = 0;
      else if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      else gap = $urandom_range(0, gap_max);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 11);
    end
  endtask

  // stop offering and let every expected result come back
  task automatic drain();
    req.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_block_limit(input logic [BLOCK_W-1:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one random item: mostly locks and matching unlocks over a small block pool
  task automatic send_random(input logic [BLOCK_W-1:0] base);
    int                 r;
    int                 idx;
    logic [BLOCK_W-1:0] b;
    logic               w;
    r = $urandom_range(0, 99);
    w = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0) b = BLOCK_W'($urandom);
    else b = base + BLOCK_W'($urandom_range(0, POOL - 1));
    if (held_q.size() > 14 && r < 44) r = 60;
    if (r < 44) begin
      held_q.push_back(b);
      send_item(KIND_LOCK, b, w);
    end else if (r < 84) begin
      if (held_q.size() != 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, held_q.size() - 1);
        b   = held_q[idx];
        held_q.delete(idx);
      end
      send_item(KIND_UNLOCK, b, w);
    end else if (r < 96) begin
      send_item(KIND_FLUSH, b, w);
    end else begin
      send_item(KIND_SPARE, b, w);
    end
  endtask

  initial begin
    logic [BLOCK_W-1:0] v;
    logic [BLOCK_W-1:0] base;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req.valid      = 1'b0;
    req.kind       = '0;
    req.block      = '0;
    req.write_flag = 1'b0;
    burst_left     = 0;
    gap_max        = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, every operation and every status but lock-full and no-buffer
    write_block_limit('1);
    send_item(KIND_LOCK, '0, 1'b0);
    send_item(KIND_LOCK, '1, 1'b1);
    send_item(KIND_LOCK, 32'hFFFF_FFFE, 1'b0);
    send_item(KIND_LOCK, '0, 1'b0);
    send_item(KIND_UNLOCK, '0, 1'b1);
    send_item(KIND_UNLOCK, '0, 1'b0);
    send_item(KIND_UNLOCK, '0, 1'b0);
    send_item(KIND_UNLOCK, 32'h1234_5678, 1'b1);
    send_item(KIND_FLUSH, '0, 1'b0);
    send_item(KIND_SPARE, '1, 1'b1);
    send_item(KIND_UNLOCK, 32'hFFFF_FFFE, 1'b1);
    send_item(KIND_FLUSH, '1, 1'b1);
    send_item(KIND_FLUSH, '0, 1'b0);
    send_item(KIND_LOCK, 32'hA5A5_A5A5, 1'b0);
    send_item(KIND_UNLOCK, 32'hA5A5_A5A5, 1'b1);
    send_item(KIND_LOCK, 32'h5A5A_5A5A, 1'b1);

    // random phases, each with its own disk size and pool straddling the limit
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: v = 32'd1;
        1: v = 32'd40;
        2: begin
          v = $urandom;
          if (v == '0) v = 32'd1;
        end
        3: v = 32'h8000_0000;
        default: v = '1;
      endcase
      base    = (v > 32'd12) ? v - 32'd12 : '0;
      gap_max = (p == 0) ? 0 : 1 + 2 * p;
      write_block_limit(v);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 10) rx_hold = 1'b1;
        if (p == 3 && i == PHASE_ITEMS / 2) drain();
        send_random(base);
      end
    end

    // release everything still held
    gap_max = 2;
    while (held_q.size() != 0) send_item(KIND_UNLOCK, held_q.pop_front(), 1'b1);

    // saturation: lock count at its maximum, table full of locked entries
    gap_max = 0;
    write_block_limit('1);
    for (int i = 0; i < 257; i++) send_item(KIND_LOCK, HOT_BLOCK, 1'b0);
    for (int i = 0; i < ENTRIES + 1; i++) send_item(KIND_LOCK, FILL_BASE + BLOCK_W'(i), 1'b0);
    send_item(KIND_FLUSH, '0, 1'b0);
    for (int i = 0; i < ENTRIES + 1; i++)
      send_item(KIND_UNLOCK, FILL_BASE + BLOCK_W'(i), 1'b1);
    send_item(KIND_FLUSH, '0, 1'b0);
    for (int i = 0; i < 3; i++) send_item(KIND_LOCK, FILL_BASE + BLOCK_W'(64 + i), 1'b0);
    send_item(KIND_UNLOCK, HOT_BLOCK, 1'b1);

    // wait for the tail and give the verdict
    drain();
    if (errors == 0 && outstanding == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
